### hw/rtl/ptw_pkg.sv
// Shared types, entry-format constants and helpers for the page-table engine.
// No dependencies; imported by ptw_store, page_table_map_and_walk and the testbench.
`timescale 1ns / 1ps

package ptw_pkg;

    localparam int INDEX_BITS       = 9;
    localparam int PAGE_OFFSET_BITS = 12;
    localparam int SIGN_BIT         = 47;
    localparam int LEVELS           = 4;
    localparam int ENTRIES          = 1 << INDEX_BITS;
    localparam int LVL_W            = 3;

    // Entry format
    localparam logic [63:0] E_PRESENT    = 64'h0000_0000_0000_0001;
    localparam logic [63:0] E_LARGE      = 64'h0000_0000_0000_0080;
    localparam logic [63:0] E_ADDR       = 64'h000F_FFFF_FFFF_F000;
    localparam logic [63:0] E_LINK_FLAGS = 64'h0000_0000_0000_0003;

    typedef struct packed {
        logic        mode;
        logic [63:0] virtual_addr;
        logic [63:0] physical_addr;
        logic [63:0] byte_count;
        logic [63:0] map_flags;
    } ptw_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] physical_out;
        logic [63:0] flags_out;
    } ptw_out_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD      = 3'd1,
        ST_UNMAPPED = 3'd2,
        ST_CONFLICT = 3'd3,
        ST_FULL     = 3'd4
    } ptw_status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_CHECK2,
        S_SIZE,
        S_READ,
        S_EVAL,
        S_DONE
    } ptw_state_t;

    localparam logic       MODE_MAP       = 1'b0;
    localparam logic       MODE_TRANSLATE = 1'b1;
    localparam logic [2:0] LVL_4K         = 3'd1;
    localparam logic [2:0] LVL_2M         = 3'd2;
    localparam logic [2:0] LVL_1G         = 3'd3;

    // Upper bits all equal to the sign bit
    function automatic logic is_canonical(input logic [63:0] a);
        return (a[63:SIGN_BIT] == '0) || (&a[63:SIGN_BIT]);
    endfunction

    // Table index for a given level (1 = last level)
    function automatic logic [INDEX_BITS-1:0] level_index(input logic [63:0] va,
                                                          input logic [LVL_W-1:0] lvl);
        logic [INDEX_BITS-1:0] idx;
        idx = '0;
        for (int l = 1; l <= LEVELS; l++)
        begin
            if (lvl == LVL_W'(l))
                idx = va[PAGE_OFFSET_BITS + INDEX_BITS * (l - 1) +: INDEX_BITS];
        end
        return idx;
    endfunction

    // Offset mask of the span covered by one entry at a level
    function automatic logic [63:0] span_mask(input logic [LVL_W-1:0] lvl);
        logic [63:0] m;
        m = '0;
        for (int l = 1; l <= LEVELS; l++)
        begin
            if (lvl == LVL_W'(l))
                m = {64{1'b1}} >> (64 - (PAGE_OFFSET_BITS + INDEX_BITS * (l - 1)));
        end
        return m;
    endfunction

    // Page size for a leaf level
    function automatic logic [63:0] leaf_bytes(input logic [LVL_W-1:0] lvl);
        return span_mask(lvl) + 64'd1;
    endfunction

endpackage

### hw/rtl/ptw_store.sv
// Table-frame store: one write port, one read port, registered read data.
// Depends on ptw_pkg, which it imports.
`timescale 1ns / 1ps

module ptw_store
    import ptw_pkg::*;
#(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [63:0]   wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [63:0]   rd_data
);

    logic [63:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### hw/rtl/page_table_map_and_walk.sv
// Four-level page-table engine: map and translate sequencer over its own frame store.
// Depends on ptw_pkg and ptw_store.
`timescale 1ns / 1ps

// One word in gives one word out. A translate is accepted in S_IDLE, then reads the
// store (S_READ) and evaluates the entry (S_EVAL) for each level walked, and S_DONE
// hands the result to the output register. A map is accepted, runs its range checks
// in S_CHECK and S_CHECK2, then for each page picks the page size in S_SIZE and reads
// and evaluates one entry per level from the root down to the leaf; the single read
// port of the frame store sets this pace. After reset the store is swept to zero, one
// entry a cycle, and no word is accepted meanwhile.
// Frames are handed out in order and never freed, so they are still zero when taken.
module page_table_map_and_walk
    import ptw_pkg::*;
#(
    parameter int TABLE_FRAMES = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  ptw_in_t  in_word,
    output logic     out_valid,
    input  logic     out_stall,
    output ptw_out_t out_word,
    input  logic     cfg_write,
    input  logic     cfg_data
);

    localparam int SW    = $clog2(TABLE_FRAMES);
    localparam int AW    = SW + INDEX_BITS;
    localparam int FW    = $clog2(TABLE_FRAMES + 1);
    localparam int DEPTH = TABLE_FRAMES * ENTRIES;

    ptw_state_t        state_reg, state_next;
    logic              mode_reg, mode_next;
    logic [63:0]       va_reg, va_next;
    logic [63:0]       pa_reg, pa_next;
    logic [63:0]       left_reg, left_next;
    logic [63:0]       flags_reg, flags_next;
    logic [64:0]       end_reg, end_next;
    logic              pa_ovf_reg, pa_ovf_next;
    logic              huge_reg;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic [LVL_W-1:0]  leaf_reg, leaf_next;
    logic [SW-1:0]     slot_reg, slot_next;
    logic [FW-1:0]     frames_reg, frames_next;
    logic [AW-1:0]     clr_reg, clr_next;
    ptw_status_t       res_status_reg, res_status_next;
    logic [63:0]       res_pa_reg, res_pa_next;
    logic [63:0]       res_fl_reg, res_fl_next;
    logic              out_valid_reg, out_valid_next;
    ptw_out_t          out_word_reg, out_word_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [63:0]       wr_data;
    logic [AW-1:0]     rd_addr;
    logic [63:0]       rd_data;

    logic [39:0]       link_field;
    logic [SW-1:0]     link_slot;
    logic [64:0]       pa_sum;
    logic [63:0]       size;

    // frame store
    ptw_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_addr    = {slot_reg, level_index(va_reg, level_reg)};
    assign link_field = rd_data[51:12];
    assign link_slot  = (link_field < 40'(TABLE_FRAMES)) ? link_field[SW-1:0] : '0;
    assign pa_sum     = {1'b0, pa_reg} + {1'b0, left_reg};
    assign size       = leaf_bytes(leaf_reg);

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            huge_reg <= 1'b0;
        else if (cfg_write)
            huge_reg <= cfg_data;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            frames_reg    <= FW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            frames_reg    <= frames_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        va_reg         <= va_next;
        pa_reg         <= pa_next;
        left_reg       <= left_next;
        flags_reg      <= flags_next;
        end_reg        <= end_next;
        pa_ovf_reg     <= pa_ovf_next;
        level_reg      <= level_next;
        leaf_reg       <= leaf_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_pa_reg     <= res_pa_next;
        res_fl_reg     <= res_fl_next;
        out_word_reg   <= out_word_next;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        va_next         = va_reg;
        pa_next         = pa_reg;
        left_next       = left_reg;
        flags_next      = flags_reg;
        end_next        = end_reg;
        pa_ovf_next     = pa_ovf_reg;
        level_next      = level_reg;
        leaf_next       = leaf_reg;
        slot_next       = slot_reg;
        frames_next     = frames_reg;
        clr_next        = clr_reg;
        res_status_next = res_status_reg;
        res_pa_next     = res_pa_reg;
        res_fl_next     = res_fl_reg;
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        wr_en           = 1'b0;
        wr_addr         = rd_addr;
        wr_data         = '0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next   = in_word.mode;
                    va_next     = in_word.virtual_addr;
                    pa_next     = in_word.physical_addr;
                    left_next   = in_word.byte_count;
                    flags_next  = in_word.map_flags;
                    res_pa_next = '0;
                    res_fl_next = '0;
                    level_next  = LVL_W'(LEVELS);
                    slot_next   = '0;
                    if (in_word.mode == MODE_MAP)
                        state_next = S_CHECK;
                    else if (!is_canonical(in_word.virtual_addr))
                    begin
                        res_status_next = ST_BAD;
                        state_next      = S_DONE;
                    end
                    else
                        state_next = S_READ;
                end
            end

            // range end and physical overflow
            S_CHECK:
            begin
                end_next    = {1'b0, va_reg} + {1'b0, left_reg};
                pa_ovf_next = pa_sum[64];
                state_next  = S_CHECK2;
            end

            S_CHECK2:
            begin
                if (left_reg == '0 || va_reg[11:0] != '0 || pa_reg[11:0] != '0 ||
                    left_reg[11:0] != '0 || end_reg[64] || pa_ovf_reg ||
                    !is_canonical(va_reg) || !is_canonical(end_reg[63:0] - 64'd1) ||
                    (flags_reg & (E_ADDR | E_LARGE)) != '0)
                begin
                    res_status_next = ST_BAD;
                    state_next      = S_DONE;
                end
                else
                    state_next = S_SIZE;
            end

            // largest aligned page that fits; 1 GiB only when huge pages are enabled
            S_SIZE:
            begin
                priority if (huge_reg && left_reg[63:30] != '0 && va_reg[29:0] == '0 &&
                             pa_reg[29:0] == '0)
                    leaf_next = LVL_1G;
                else if (left_reg[63:21] != '0 && va_reg[20:0] == '0 &&
                         pa_reg[20:0] == '0)
                    leaf_next = LVL_2M;
                else
                    leaf_next = LVL_4K;
                level_next = LVL_W'(LEVELS);
                slot_next  = '0;
                state_next = S_READ;
            end

            S_READ:
            begin
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                if (mode_reg == MODE_TRANSLATE)
                begin
                    priority if (!rd_data[0])
                    begin
                        res_status_next = ST_UNMAPPED;
                        state_next      = S_DONE;
                    end
                    else if (level_reg == LVL_4K ||
                             (level_reg < LVL_W'(LEVELS) && rd_data[7]))
                    begin
                        res_pa_next     = (rd_data & E_ADDR) + (va_reg & span_mask(level_reg));
                        res_fl_next     = rd_data & ~E_ADDR;
                        res_status_next = ST_OK;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        slot_next  = link_slot;
                        level_next = level_reg - LVL_W'(1);
                        state_next = S_READ;
                    end
                end
                else if (level_reg > leaf_reg)
                begin
                    // descend, taking a fresh frame where the link is missing
                    priority if (rd_data[0] && rd_data[7])
                    begin
                        res_status_next = ST_CONFLICT;
                        state_next      = S_DONE;
                    end
                    else if (rd_data[0])
                    begin
                        slot_next  = link_slot;
                        level_next = level_reg - LVL_W'(1);
                        state_next = S_READ;
                    end
                    else if (frames_reg >= FW'(TABLE_FRAMES))
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_data     = ({52'(frames_reg), 12'd0} & E_ADDR) | E_LINK_FLAGS;
                        frames_next = frames_reg + FW'(1);
                        slot_next   = frames_reg[SW-1:0];
                        level_next  = level_reg - LVL_W'(1);
                        state_next  = S_READ;
                    end
                end
                else
                begin
                    // leaf entry
                    if (rd_data[0])
                    begin
                        res_status_next = ST_CONFLICT;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        wr_data   = (pa_reg & E_ADDR) | flags_reg | E_PRESENT |
                                    ((leaf_reg != LVL_4K) ? E_LARGE : 64'd0);
                        va_next   = va_reg + size;
                        pa_next   = pa_reg + size;
                        left_next = left_reg - size;
                        if (left_reg == size)
                        begin
                            res_status_next = ST_OK;
                            state_next      = S_DONE;
                        end
                        else
                            state_next = S_SIZE;
                    end
                end
            end

            // hand over to the output register
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next             = 1'b1;
                    out_word_next.status       = res_status_reg;
                    out_word_next.physical_out = res_pa_reg;
                    out_word_next.flags_out    = res_fl_reg;
                    state_next                 = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### sim/tb_page_table_map_and_walk.sv
// Self-checking testbench for page_table_map_and_walk: directed table, then random words.
// Depends on ptw_pkg and the page_table_map_and_walk RTL; reads no files.
`timescale 1ns / 1ps

module tb_page_table_map_and_walk;
    import ptw_pkg::*;

    localparam int FRAMES     = 64;
    localparam int WATCHDOG   = FRAMES * ENTRIES * 64;
    localparam logic [63:0] SZ4K = 64'h1000;
    localparam logic [63:0] SZ2M = 64'h20_0000;
    localparam logic [63:0] SZ1G = 64'h4000_0000;
    localparam logic [63:0] HI_BASE = 64'hFFFF_8000_0000_0000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    ptw_in_t  in_word;
    logic     out_valid;
    logic     out_stall;
    ptw_out_t out_word;
    logic     cfg_write;
    logic     cfg_data;

    // Model of the table store, indexed by frame and slot
    logic [63:0] shadow_tables [0:FRAMES*ENTRIES-1];
    int          shadow_frames_used;
    logic        shadow_huge_en;

    ptw_out_t    pending_results [$];
    int          mismatches;
    int          idle_cycles;
    logic        out_pattern_hold;

    page_table_map_and_walk #(.TABLE_FRAMES(FRAMES)) i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int slot_pos(int slot, logic [63:0] va, int lvl);
        return slot * ENTRIES + int'((va >> (PAGE_OFFSET_BITS + INDEX_BITS * (lvl - 1)))
                                     & (ENTRIES - 1));
    endfunction

    function automatic int frame_of(logic [63:0] e);
        logic [63:0] s;
        s = (e & E_ADDR) >> PAGE_OFFSET_BITS;
        return (s < FRAMES) ? int'(s) : 0;
    endfunction

    function automatic logic canon(logic [63:0] a);
        return (a[63:SIGN_BIT] == '0) || (&a[63:SIGN_BIT]);
    endfunction

    // Descend one level, creating a table if missing
    function automatic ptw_status_t descend(inout int slot, input int lvl,
                                            input logic [63:0] va);
        int          p;
        logic [63:0] e;
        p = slot_pos(slot, va, lvl);
        e = shadow_tables[p];
        if ((e & E_PRESENT) != 0)
        begin
            if (lvl > 1 && (e & E_LARGE) != 0)
                return ST_CONFLICT;
            slot = frame_of(e);
            return ST_OK;
        end
        if (shadow_frames_used >= FRAMES)
            return ST_FULL;
        for (int i = 0; i < ENTRIES; i++)
            shadow_tables[shadow_frames_used * ENTRIES + i] = '0;
        shadow_tables[p] = ((64'(shadow_frames_used) << PAGE_OFFSET_BITS) & E_ADDR)
                           | E_LINK_FLAGS;
        slot = shadow_frames_used;
        shadow_frames_used++;
        return ST_OK;
    endfunction

    function automatic ptw_status_t write_page(logic [63:0] va, logic [63:0] pa,
                                               logic [63:0] sz, logic [63:0] fl);
        int          leaf;
        int          slot;
        int          p;
        ptw_status_t st;
        leaf = (sz == SZ1G) ? 3 : ((sz == SZ2M) ? 2 : 1);
        slot = 0;
        for (int lvl = LEVELS; lvl > leaf; lvl--)
        begin
            st = descend(slot, lvl, va);
            if (st != ST_OK)
                return st;
        end
        p = slot_pos(slot, va, leaf);
        if ((shadow_tables[p] & E_PRESENT) != 0)
            return ST_CONFLICT;
        shadow_tables[p] = (pa & E_ADDR) | fl | E_PRESENT | ((leaf != 1) ? E_LARGE : 64'd0);
        return ST_OK;
    endfunction

    function automatic ptw_status_t map_range(logic [63:0] va, logic [63:0] pa,
                                              logic [63:0] len, logic [63:0] fl);
        logic [63:0] left;
        logic [63:0] sz;
        ptw_status_t st;
        left = len;
        if (len == 0 || va[11:0] != 0 || pa[11:0] != 0 || len[11:0] != 0)
            return ST_BAD;
        if (va > ~len || pa > ~len)
            return ST_BAD;
        if (!canon(va) || !canon(va + len - 64'd1))
            return ST_BAD;
        if ((fl & (E_ADDR | E_LARGE)) != 0)
            return ST_BAD;
        while (left > 0)
        begin
            if (shadow_huge_en && left >= SZ1G && va % SZ1G == 0 && pa % SZ1G == 0)
                sz = SZ1G;
            else if (left >= SZ2M && va % SZ2M == 0 && pa % SZ2M == 0)
                sz = SZ2M;
            else
                sz = SZ4K;
            st = write_page(va, pa, sz, fl);
            if (st != ST_OK)
                return st;
            va += sz;
            pa += sz;
            left -= sz;
        end
        return ST_OK;
    endfunction

    function automatic ptw_out_t predict_result(ptw_in_t w);
        ptw_out_t    r;
        int          slot;
        logic [63:0] e;
        logic [63:0] span;
        r = '0;
        if (w.mode == MODE_MAP)
        begin
            r.status = map_range(w.virtual_addr, w.physical_addr, w.byte_count, w.map_flags);
            return r;
        end
        if (!canon(w.virtual_addr))
        begin
            r.status = ST_BAD;
            return r;
        end
        slot = 0;
        for (int lvl = LEVELS; lvl >= 1; lvl--)
        begin
            e = shadow_tables[slot_pos(slot, w.virtual_addr, lvl)];
            if ((e & E_PRESENT) == 0)
                break;
            if (lvl == 1 || (lvl < LEVELS && (e & E_LARGE) != 0))
            begin
                span = 64'd1 << (PAGE_OFFSET_BITS + INDEX_BITS * (lvl - 1));
                r.status = ST_OK;
                r.physical_out = (e & E_ADDR) + (w.virtual_addr % span);
                r.flags_out = e & ~E_ADDR;
                return r;
            end
            slot = frame_of(e);
        end
        r.status = ST_UNMAPPED;
        return r;
    endfunction

    // Drive one word; the expectation is queued at acceptance.
    // Valid stays high afterwards so words can follow back to back.
    task automatic send_word(ptw_in_t w, logic use_fixed, ptw_out_t fixed);
        ptw_out_t r;
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = predict_result(w);
        if (use_fixed && r !== fixed)
            $display("directed row disagrees with predictor: %h vs %h", fixed, r);
        pending_results.push_back(use_fixed ? fixed : r);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_huge_enable(logic v);
        drain_results();
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        shadow_huge_en = v;
    endtask

    function automatic ptw_in_t map_word(logic [63:0] va, logic [63:0] pa,
                                         logic [63:0] len, logic [63:0] fl);
        ptw_in_t w;
        w = '{MODE_MAP, va, pa, len, fl};
        return w;
    endfunction

    function automatic ptw_in_t walk_word(logic [63:0] va);
        ptw_in_t w;
        w = '{MODE_TRANSLATE, va, $urandom, $urandom, $urandom};
        return w;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Legal leaf flag bits: low 12 bits except the large-page bit, plus bits 52..63
    function automatic logic [63:0] rand_flags();
        return rand64() & ~(E_ADDR | E_LARGE);
    endfunction

    // Random canonical, page-aligned virtual base within a small window
    function automatic logic [63:0] rand_va();
        logic [63:0] v;
        v = 64'($urandom_range(0, 7)) * SZ1G + 64'($urandom_range(0, 3)) * SZ2M
            + 64'($urandom_range(0, 15)) * SZ4K;
        if ($urandom_range(0, 3) == 0)
            v = v | HI_BASE;
        return v;
    endfunction

    // Result check on the output side
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            idle_cycles <= 0;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", out_word);
            end
            else
            begin
                if (out_word.status !== pending_results[0].status
                    || out_word.physical_out !== pending_results[0].physical_out
                    || out_word.flags_out !== pending_results[0].flags_out)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h",
                                 pending_results[0], out_word);
                end
                void'(pending_results.pop_front());
            end
        end
        else if (rst_n && in_valid && !in_stall)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver stall pattern: runs of stall, runs of free flow
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            out_pattern_hold = $urandom_range(0, 2) == 0;
            repeat ($urandom_range(1, out_pattern_hold ? 6 : 20))
            begin
                @(posedge clk);
                out_stall <= out_pattern_hold;
            end
        end
    end

    // Stimulus
    initial
    begin
        ptw_in_t  w;
        ptw_out_t fx;
        ptw_in_t  rows [$];
        ptw_out_t fixed_rows [$];
        logic     fixed_use [$];
        logic [63:0] va;
        logic [63:0] pa;
        int       burst;
        int       gap;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_write = 1'b0;
        cfg_data  = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        shadow_frames_used = 1;
        shadow_huge_en = 1'b0;
        for (int i = 0; i < FRAMES * ENTRIES; i++)
            shadow_tables[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: rows with fixed results, then predictor-checked ones
        fx = '0;
        fx.status = ST_UNMAPPED;
        rows.push_back(walk_word(64'h0)); fixed_rows.push_back(fx); fixed_use.push_back(1);
        fx.status = ST_BAD;
        rows.push_back(map_word(64'h0, 64'h0, 64'h0, 64'h0));
        fixed_rows.push_back(fx); fixed_use.push_back(1);
        rows.push_back(map_word(64'h10, 64'h0, SZ4K, 64'h0));
        fixed_rows.push_back(fx); fixed_use.push_back(1);
        rows.push_back(map_word(64'h0, 64'h8, SZ4K, 64'h0));
        fixed_rows.push_back(fx); fixed_use.push_back(1);
        rows.push_back(map_word(64'h0, 64'h0, 64'h801, 64'h0));
        fixed_rows.push_back(fx); fixed_use.push_back(1);
        rows.push_back(map_word(64'hFFFF_FFFF_FFFF_F000, 64'h0, 64'h2000, 64'h0));
        fixed_rows.push_back(fx); fixed_use.push_back(1);
        rows.push_back(map_word(64'h0, 64'hFFFF_FFFF_FFFF_F000, 64'h2000, 64'h0));
        fixed_rows.push_back(fx); fixed_use.push_back(1);
        rows.push_back(map_word(64'h0000_8000_0000_0000, 64'h0, SZ4K, 64'h0));
        fixed_rows.push_back(fx); fixed_use.push_back(1);
        rows.push_back(map_word(64'h0000_7FFF_FFFF_F000, 64'h0, 64'h2000, 64'h0));
        fixed_rows.push_back(fx); fixed_use.push_back(1);
        rows.push_back(map_word(64'h0, 64'h0, SZ4K, E_LARGE));
        fixed_rows.push_back(fx); fixed_use.push_back(1);
        rows.push_back(map_word(64'h0, 64'h0, SZ4K, 64'h0010_0000_0000_0000 >> 1));
        fixed_rows.push_back(fx); fixed_use.push_back(1);
        rows.push_back(walk_word(64'h0001_0000_0000_0000));
        fixed_rows.push_back(fx); fixed_use.push_back(1);
        // Predictor-checked rows: 4K, 2M, extremes of canonical space, conflicts
        rows.push_back(map_word(64'h0, 64'hFFF_FFFF_F000, SZ4K, 64'hFFF0_0000_0000_0F7E));
        rows.push_back(walk_word(64'h0FFF));
        rows.push_back(map_word(SZ2M, SZ2M * 3, SZ2M + SZ4K, 64'h2));
        rows.push_back(walk_word(SZ2M + 64'h1_2345));
        rows.push_back(map_word(SZ2M + SZ4K * 3, 64'h0, SZ4K, 64'h0));
        rows.push_back(map_word(64'h0000_7FFF_FFFF_F000, 64'h5000, SZ4K, 64'h4));
        rows.push_back(walk_word(64'h0000_7FFF_FFFF_FFFF));
        rows.push_back(map_word(HI_BASE, 64'h0, SZ4K, 64'h0));
        rows.push_back(walk_word(64'hFFFF_FFFF_FFFF_FFFF));
        rows.push_back(walk_word(HI_BASE + 64'h123));
        rows.push_back(map_word(64'h0, 64'h0, SZ4K, 64'h0));
        for (int i = fixed_rows.size(); i < rows.size(); i++)
        begin
            fixed_rows.push_back('0);
            fixed_use.push_back(0);
        end
        foreach (rows[i])
            send_word(rows[i], fixed_use[i], fixed_rows[i]);

        // Huge pages on: 1 GiB leaves, then through a 1 GiB page
        write_huge_enable(1'b1);
        send_word(map_word(SZ1G * 4, SZ1G * 2, SZ1G + SZ2M, 64'h6), 0, '0);
        send_word(walk_word(SZ1G * 4 + 64'h3ABC_DEF0), 0, '0);
        send_word(map_word(SZ1G * 4 + SZ4K, 64'h0, SZ4K, 64'h0), 0, '0);

        // Random phases, alternating the huge-page setting
        for (int phase = 0; phase < 4; phase++)
        begin
            write_huge_enable(phase[0]);
            for (int n = 0; n < 120; )
            begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst; b++, n++)
                begin
                    va = rand_va();
                    pa = 64'($urandom_range(0, 3)) * SZ1G + 64'($urandom_range(0, 7)) * SZ2M
                         + 64'($urandom_range(0, 3)) * SZ4K;
                    if ($urandom_range(0, 20) == 0)
                        pa = pa | (rand64() & E_ADDR);
                    case ($urandom_range(0, 9))
                        0, 1, 2:
                            w = map_word(va, pa, 64'($urandom_range(1, 4)) * SZ4K,
                                         rand_flags());
                        3:
                            w = map_word(va, pa, SZ2M * $urandom_range(1, 2)
                                         + 64'($urandom_range(0, 1)) * SZ4K, rand_flags());
                        4:
                            w = map_word(va, pa, SZ1G, rand_flags());
                        5:
                            w = map_word(rand64(), rand64(), rand64(), rand64());
                        6:
                            w = walk_word(rand64());
                        default:
                            w = walk_word(va + 64'($urandom_range(0, 32'h3FFF_FFFF)));
                    endcase
                    send_word(w, 0, '0);
                end
                if (n > 60 && n < 75)
                    drain_results();
                else
                begin
                    gap = $urandom_range(0, 5);
                    if (gap > 0)
                    begin
                        in_valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
            end
        end

        // Wait out the last results
        drain_results();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/ptw_pkg.sv
hw/rtl/ptw_store.sv
hw/rtl/page_table_map_and_walk.sv
sim/tb_page_table_map_and_walk.sv
